// File: hdl/swmf_pkg.sv
// Package: shared constants, register map and types of the sliding-window max filter.
`default_nettype none
package swmf_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int WINDOW_MAX_DEF   = 64;

  // Configuration register and counters
  localparam int CFG_W    = 7;
  localparam int AGE_W    = 7;
  localparam int FILL_W   = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [AGE_W-1:0]  AGE_SAT  = '1;
  localparam logic [FILL_W-1:0] FILL_SAT = '1;
  localparam logic [CFG_W-1:0]  WINDOW_RESET = 7'd1;

  // Word index of each register (paddr above the byte-lane bits)
  localparam logic [ADDR_W-3:0] REG_WINDOW_SIZE = 1'b0;

  // Broadcast control shared by every cell in the chain
  typedef struct packed {
    logic step;   // a sample word is accepted this cycle
    logic purge;  // shift the chain toward the front, no new entry
    logic drop;   // cells take their state from the right neighbor
    logic clr;    // new sequence: all held entries are discarded
  } cell_ctrl_t;

  // Control part of one queue entry
  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
  } cell_st_t;

endpackage
`default_nettype wire

// File: hdl/swmf_in_if.sv
// Interface: input sample channel (valid/ready with sample and start flag).
`default_nettype none
interface swmf_in_if #(
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface
`default_nettype wire

// File: hdl/swmf_out_if.sv
// Interface: result channel (valid/ready with the window maximum).
`default_nettype none
interface swmf_out_if #(
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, window_max, input ready);
  modport sink   (input valid, window_max, output ready);
endinterface
`default_nettype wire

// File: hdl/swmf_cell.sv
// One cell of the monotonic queue chain: holds a value and its age.
`default_nettype none
module swmf_cell #(
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swmf_pkg::cell_ctrl_t           ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           left_keep,
  input  swmf_pkg::cell_st_t             right_st,
  input  logic signed [SAMPLE_WIDTH-1:0] right_value,
  output swmf_pkg::cell_st_t             cur_st,
  output logic signed [SAMPLE_WIDTH-1:0] cur_value,
  output logic                           keep,
  output logic signed [SAMPLE_WIDTH-1:0] step_value
);
  import swmf_pkg::*;

  cell_st_t                       st_r, st_nxt;
  logic signed [SAMPLE_WIDTH-1:0] value_r, value_nxt;
  cell_st_t                       src_st;
  logic signed [SAMPLE_WIDTH-1:0] src_value;

  // Source entry: own, or the right neighbor's when the front entry expires
  always_comb begin
    src_st    = ctrl.drop ? right_st    : st_r;
    src_value = ctrl.drop ? right_value : value_r;
  end

  // Entry survives unless the new sample is strictly larger (keep is a prefix)
  assign keep       = src_st.valid && !ctrl.clr && !(src_value < sample);
  assign step_value = keep ? src_value : sample;

  // Next state: keep the entry, take the new sample at the first free slot,
  // or go empty
  always_comb begin
    st_nxt    = st_r;
    value_nxt = value_r;
    if (ctrl.step) begin
      value_nxt = step_value;
      if (keep) begin
        st_nxt.valid = 1'b1;
        st_nxt.age   = (src_st.age == AGE_SAT) ? src_st.age : src_st.age + 1'b1;
      end else if (left_keep) begin
        st_nxt.valid = 1'b1;
        st_nxt.age   = '0;
      end else begin
        st_nxt.valid = 1'b0;
      end
    end else if (ctrl.purge) begin
      st_nxt    = src_st;
      value_nxt = src_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign cur_st    = st_r;
  assign cur_value = value_r;

endmodule
`default_nettype wire

// File: hdl/swmf_obuf.sv
// Two-word output buffer: decouples the queue from a stalled result sink.
`default_nettype none
module swmf_obuf #(
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic signed [SAMPLE_WIDTH-1:0] push_value,
  output logic                           full,
  swmf_out_if.source                     out_chan
);
  import swmf_pkg::*;

  logic [1:0]                     count_r, count_nxt;
  logic signed [SAMPLE_WIDTH-1:0] head_r, head_nxt;
  logic signed [SAMPLE_WIDTH-1:0] tail_r, tail_nxt;
  logic                           pop;

  assign pop                 = out_chan.valid && out_chan.ready;
  assign out_chan.valid      = (count_r != 2'd0);
  assign out_chan.window_max = head_r;
  assign full                = (count_r == 2'd2);

  // Head is the word on the port; tail holds the word behind it
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) head_nxt = push_value;
        else tail_nxt = push_value;
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        head_nxt  = tail_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = push_value;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/sliding_window_max_filter.sv
// Sliding-window maximum filter over a chain of monotonic-queue cells.
// Takes one sample word per clock unless stalled and returns, once window_size
// samples of the current sequence have arrived, the largest of the last
// window_size samples, registered into the output buffer; start_req on a
// sample discards the held history and starts a new sequence. The queue lives
// in a row of WINDOW_MAX cells with the oldest candidate in cell 0; each cell
// decides from its right neighbor and a broadcast compare against the new
// sample, so the per-cycle path is one compare and a mux. Throughput is one
// sample per cycle unless stalled. After window_size is lowered, the input
// stalls while the chain shifts out each front entry that has fallen out of
// the new window. A two-word output buffer lets inputs continue while a
// result waits; the input stalls while it is full. window_size sits at byte
// address 0; 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX.
`default_nettype none
module sliding_window_max_filter #(
  parameter int WINDOW_MAX   = swmf_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  swmf_in_if.sink                       in_chan,
  swmf_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [swmf_pkg::DATA_W-1:0]   pwdata,
  output logic [swmf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import swmf_pkg::*;

  localparam int N         = WINDOW_MAX;
  localparam int WIN_CLAMP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;

  logic [CFG_W-1:0]  window_size_r;
  logic [CFG_W-1:0]  w_eff;
  logic [FILL_W-1:0] fill_r, fill_base, fill_nxt;
  logic              cfg_wr, reg_hit;
  logic              accept, purge, drop_step, emit, full;
  cell_ctrl_t        ctrl;

  cell_st_t                       st_a   [N+1];
  logic signed [SAMPLE_WIDTH-1:0] val_a  [N+1];
  logic                           keep_a [N];
  logic                           lk_a   [N];
  logic signed [SAMPLE_WIDTH-1:0] sv_a   [N];

  // Configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {{(DATA_W-CFG_W){1'b0}}, window_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_size_r <= pwdata[CFG_W-1:0];
    end
  end

  // Effective window length
  always_comb begin
    if (window_size_r == '0) w_eff = CFG_W'(1);
    else if (window_size_r > CFG_W'(WIN_CLAMP)) w_eff = CFG_W'(WIN_CLAMP);
    else w_eff = window_size_r;
  end

  // Front entry checks: purge when already outside the window, drop on a
  // step when it ages out with this sample
  assign purge     = st_a[0].valid && (st_a[0].age >= w_eff);
  assign drop_step = !in_chan.start_req && st_a[0].valid &&
                     (({1'b0, st_a[0].age} + 8'd1) >= {1'b0, w_eff});

  assign in_chan.ready = !purge && !full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    ctrl.step  = accept;
    ctrl.purge = purge;
    ctrl.drop  = purge || drop_step;
    ctrl.clr   = in_chan.start_req;
  end

  // Cell chain; the slot past the last cell is always empty
  assign st_a[N]  = '0;
  assign val_a[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lk_a[i] = 1'b1;
    end else begin : g_body
      assign lk_a[i] = keep_a[i-1];
    end

    swmf_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (in_chan.sample),
      .left_keep   (lk_a[i]),
      .right_st    (st_a[i+1]),
      .right_value (val_a[i+1]),
      .cur_st      (st_a[i]),
      .cur_value   (val_a[i]),
      .keep        (keep_a[i]),
      .step_value  (sv_a[i])
    );
  end

  // Sequence fill count, saturating
  assign fill_base = in_chan.start_req ? '0 : fill_r;
  assign fill_nxt  = (fill_base == FILL_SAT) ? fill_base : fill_base + 1'b1;
  assign emit      = accept && (fill_nxt >= w_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // Result: the new front of the queue
  swmf_obuf #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (emit),
    .push_value (sv_a[0]),
    .full       (full),
    .out_chan   (out_chan)
  );

endmodule
`default_nettype wire

// File: hdl/swmf_chk.sv
// Checker: port-level properties of the sliding-window max filter, bound to the top.
`default_nettype none
module swmf_chk #(
  parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input logic                           in_start_req,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_window_max,
  input logic [swmf_pkg::DATA_W-1:0]    prdata,
  input logic                           pready
);
  import swmf_pkg::*;

  logic start_acc;
  assign start_acc = in_valid && in_ready && in_start_req && !out_valid;

  // A waiting result word is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_window_max)))
    else $error("result word changed or vanished while stalled");

  // No stale result right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Window of one: a new sequence returns its first sample next cycle
  a_win_one: assert property (@(posedge clk) disable iff (!rst_n)
    (start_acc && (prdata[6:1] == 6'd0)) |=>
      (out_valid && (out_window_max == $past(in_sample))))
    else $error("window of one did not return the sample");

  // Longer window: the first sample of a sequence gives no result
  a_win_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (start_acc && (prdata[6:1] != 6'd0)) |=> !out_valid)
    else $error("result before the window filled");

  // Config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind sliding_window_max_filter swmf_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swmf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_sample      (in_chan.sample),
  .in_start_req   (in_chan.start_req),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_window_max (out_chan.window_max),
  .prdata         (prdata),
  .pready         (pready)
);
`default_nettype wire
